>>> rtl/apq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_pkg
// Shared codes and the command and status bundles between the controller
// and the datapath of the array priority queue.
// ----------------------------------------------------------------------------
package apq_pkg;

   // field widths fixed by the interface
   localparam int OP_W     = 2;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // request opcodes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic load_req;   // capture request, set status, restart scan
      logic do_insert;  // append captured pair, count up
      logic scan_step;  // read next priority, advance scan index
      logic fetch;      // read winner value and last entry
      logic commit;     // take result, move last entry on a delete
      logic rsp_load;   // load response registers
   } apq_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_empty;
      logic count_full;
      logic scan_last;  // scan index sits on the last stored entry
   } apq_stat_type;

endpackage

>>> rtl/array_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_priority_queue
// Max-priority queue of value and priority pairs in an unsorted array.
// ----------------------------------------------------------------------------
// One request is worked at a time and each gives one response. An insert
// appends the pair, or is refused with a full status when DEPTH entries are
// stored. A delete or peek reads the stored priorities one per cycle through
// the single read port of the priority memory, in these steps: the accepting
// cycle, the scan reads, a compare drain, a read of the winning value and of
// the last entry, a write-back and the response load. On equal priorities the
// lowest index wins; a delete moves the last entry into the freed slot. Delete
// or peek on an empty queue returns an empty status. A finished response
// waits in an output register, and the next request is taken as soon as
// that register is loaded.
// The memories are not cleared after reset; only written entries are ever read.
// entry_count shows the low 5 bits of the stored count.
// ----------------------------------------------------------------------------
module array_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic        [apq_pkg::OP_W-1:0]     req_opcode,
   input  logic signed [apq_pkg::DATA_W-1:0]   req_value_in,
   input  logic signed [apq_pkg::DATA_W-1:0]   req_priority_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic        [apq_pkg::STATUS_W-1:0] rsp_status,
   output logic signed [apq_pkg::DATA_W-1:0]   rsp_value_out,
   output logic        [apq_pkg::COUNT_W-1:0]  rsp_entry_count
);
   import apq_pkg::*;

   apq_cmd_type  cmd;
   apq_stat_type stat;

   // sequencer
   apq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   // storage, scan and response registers
   apq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_opcode),
      .req_value_in    (req_value_in),
      .req_priority_in (req_priority_in),
      .rsp_status      (rsp_status),
      .rsp_value_out   (rsp_value_out),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

>>> rtl/apq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_datapath
// Value and priority memories, entry count, sequential max scan and the
// response registers.
// ----------------------------------------------------------------------------
module apq_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  apq_pkg::apq_cmd_type                   cmd,
   output apq_pkg::apq_stat_type                  stat,
   input  logic        [apq_pkg::OP_W-1:0]        req_opcode,
   input  logic signed [apq_pkg::DATA_W-1:0]      req_value_in,
   input  logic signed [apq_pkg::DATA_W-1:0]      req_priority_in,
   output logic        [apq_pkg::STATUS_W-1:0]    rsp_status,
   output logic signed [apq_pkg::DATA_W-1:0]      rsp_value_out,
   output logic        [apq_pkg::COUNT_W-1:0]     rsp_entry_count
);
   import apq_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   // storage
   logic        [DATA_W-1:0] value_mem [DEPTH];
   logic        [DATA_W-1:0] prio_mem  [DEPTH];

   logic        [CW-1:0]       count_ff;
   logic        [OP_W-1:0]     op_ff;
   logic        [DATA_W-1:0]   value_ff;
   logic        [DATA_W-1:0]   prio_ff;
   logic        [STATUS_W-1:0] status_ff;
   logic        [DATA_W-1:0]   result_ff;

   logic        [IW-1:0]       scan_idx_ff;
   logic                       cmp_valid_ff;
   logic        [IW-1:0]       cmp_idx_ff;
   logic        [IW-1:0]       best_idx_ff;
   logic signed [DATA_W-1:0]   best_prio_ff;

   logic signed [DATA_W-1:0]   prio_rd_ff;
   logic        [DATA_W-1:0]   value_rd_a_ff;
   logic        [DATA_W-1:0]   value_rd_b_ff;

   logic        [STATUS_W-1:0] rsp_status_ff;
   logic        [DATA_W-1:0]   rsp_value_ff;
   logic        [COUNT_W-1:0]  rsp_count_ff;

   logic        [CW-1:0]       count_dec;
   logic        [IW-1:0]       last_idx;
   logic        [IW-1:0]       prio_rd_addr;
   logic                       wr_en;
   logic        [IW-1:0]       wr_addr;
   logic        [DATA_W-1:0]   wr_value;
   logic        [DATA_W-1:0]   wr_prio;
   logic        [CW+COUNT_W-1:0] count_wide;
   logic        [STATUS_W-1:0] status_in;
   logic                       take_best;

   // count derived status
   assign count_dec        = count_ff - CW'(1);
   assign last_idx         = count_dec[IW-1:0];
   assign stat.count_empty = (count_ff == '0);
   assign stat.count_full  = (count_ff == CW'(DEPTH));
   assign stat.scan_last   = (scan_idx_ff == last_idx);

   // status of the new request, known at capture
   always_comb begin
      status_in = STATUS_OK;
      priority if (req_opcode == OP_INSERT && stat.count_full) begin
         status_in = STATUS_FULL;
      end else if ((req_opcode == OP_DELETE || req_opcode == OP_PEEK) &&
                   stat.count_empty) begin
         status_in = STATUS_EMPTY;
      end
   end

   // request capture and result
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff     <= req_opcode;
         value_ff  <= req_value_in;
         prio_ff   <= req_priority_in;
         status_ff <= status_in;
         result_ff <= '0;
      end else if (cmd.commit) begin
         result_ff <= value_rd_a_ff;
      end
   end

   // entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.do_insert) begin
         count_ff <= count_ff + CW'(1);
      end else if (cmd.commit && op_ff == OP_DELETE) begin
         count_ff <= count_dec;
      end
   end

   // scan index
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         scan_idx_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_idx_ff <= scan_idx_ff + IW'(1);
      end
   end

   // compare stage works in the cycle after the priority read
   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= cmd.scan_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step) begin
         cmp_idx_ff <= scan_idx_ff;
      end
   end

   // first entry always taken, later ones only when strictly greater
   assign take_best = cmp_valid_ff && (cmp_idx_ff == '0 || prio_rd_ff > best_prio_ff);

   always_ff @(posedge clock) begin
      if (take_best) begin
         best_idx_ff  <= cmp_idx_ff;
         best_prio_ff <= prio_rd_ff;
      end
   end

   // shared write port: insert at the end, or move last entry into the hole
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = count_ff[IW-1:0];
      wr_value = value_ff;
      wr_prio  = prio_ff;
      priority if (cmd.do_insert) begin
         wr_en = 1'b1;
      end else if (cmd.commit && op_ff == OP_DELETE) begin
         wr_en    = 1'b1;
         wr_addr  = best_idx_ff;
         wr_value = value_rd_b_ff;
         wr_prio  = prio_rd_ff;
      end
   end

   assign prio_rd_addr = cmd.fetch ? last_idx : scan_idx_ff;

   // priority memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         prio_mem[wr_addr] <= wr_prio;
      end
      if (cmd.scan_step || cmd.fetch) begin
         prio_rd_ff <= prio_mem[prio_rd_addr];
      end
   end

   // value memory, one write and two registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_mem[wr_addr] <= wr_value;
      end
      if (cmd.fetch) begin
         value_rd_a_ff <= value_mem[best_idx_ff];
         value_rd_b_ff <= value_mem[last_idx];
      end
   end

   // response registers
   assign count_wide = {{COUNT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_value_ff  <= result_ff;
         rsp_count_ff  <= count_wide[COUNT_W-1:0];
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_value_out   = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

>>> rtl/apq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_ctrl
// Sequencer for the array priority queue: request capture, scan, fetch,
// commit and response hand-off.
// ----------------------------------------------------------------------------
module apq_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [apq_pkg::OP_W-1:0]      req_opcode,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  apq_pkg::apq_stat_type         stat,
   output apq_pkg::apq_cmd_type          cmd
);
   import apq_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_INSERT   = 3'd1;
   localparam logic [2:0] S_SCAN     = 3'd2;
   localparam logic [2:0] S_SCAN_END = 3'd3;
   localparam logic [2:0] S_FETCH    = 3'd4;
   localparam logic [2:0] S_COMMIT   = 3'd5;
   localparam logic [2:0] S_DONE     = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_req = 1'b1;
               priority if (req_opcode == OP_INSERT) begin
                  state_in = stat.count_full ? S_DONE : S_INSERT;
               end else if (req_opcode == OP_DELETE || req_opcode == OP_PEEK) begin
                  state_in = stat.count_empty ? S_DONE : S_SCAN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_INSERT: begin
            cmd.do_insert = 1'b1;
            state_in      = S_DONE;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            state_in = S_FETCH;
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response valid holds until taken
   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> dv/tb_array_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_array_priority_queue
// Self-checking bench for the array priority queue. A shadow copy of the
// stored pairs predicts status, value and count for every accepted request.
// Responses are compared in order as they are accepted. Directed cases cover
// the empty queue, the unused opcode, priority ties and field extremes. Random
// fill and drain bursts run under three idling mixes, and one long response
// hold-off backs the queue up into its request side.
// ----------------------------------------------------------------------------
module tb_array_priority_queue;
   import apq_pkg::*;

   localparam int DEPTH = 16;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] value;
      logic [COUNT_W-1:0]       count;
   } queue_rsp_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [OP_W-1:0]            req_opcode = OP_INSERT;
   logic signed [DATA_W-1:0]   req_value_in = '0;
   logic signed [DATA_W-1:0]   req_priority_in = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic signed [DATA_W-1:0]   rsp_value_out;
   logic [COUNT_W-1:0]         rsp_entry_count;

   // shadow of the queue contents
   logic signed [DATA_W-1:0]   shadow_value [DEPTH];
   logic signed [DATA_W-1:0]   shadow_priority [DEPTH];
   int                         shadow_count = 0;
   queue_rsp_type              pending_rsp [$];

   int                         fail_count = 0;
   int                         snd_idle_pct = 0;
   int                         rcv_idle_pct = 0;
   int                         hold_left = 0;

   array_priority_queue #(
      .DEPTH(DEPTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_value_in    (req_value_in),
      .req_priority_in (req_priority_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_value_out   (rsp_value_out),
      .rsp_entry_count (rsp_entry_count)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // apply one request to the shadow queue and record the expected response
   task automatic apply_queue_op(input logic [OP_W-1:0] op,
                                 input logic signed [DATA_W-1:0] val,
                                 input logic signed [DATA_W-1:0] pri);
      queue_rsp_type rsp;
      int best;
      int last;
      rsp.status = STATUS_OK;
      rsp.value = '0;
      case (op)
         OP_INSERT: begin
            if (shadow_count >= DEPTH) begin
               rsp.status = STATUS_FULL;
            end else begin
               shadow_value[shadow_count] = val;
               shadow_priority[shadow_count] = pri;
               shadow_count++;
            end
         end
         OP_DELETE, OP_PEEK: begin
            if (shadow_count == 0) begin
               rsp.status = STATUS_EMPTY;
            end else begin
               // first entry of the highest priority wins
               best = 0;
               for (int i = 1; i < shadow_count; i++) begin
                  if (shadow_priority[i] > shadow_priority[best]) best = i;
               end
               rsp.value = shadow_value[best];
               if (op == OP_DELETE) begin
                  last = shadow_count - 1;
                  shadow_value[best] = shadow_value[last];
                  shadow_priority[best] = shadow_priority[last];
                  shadow_count = last;
               end
            end
         end
         default: ;
      endcase
      rsp.count = COUNT_W'(shadow_count);
      pending_rsp.push_back(rsp);
   endtask

   // offer one request, with random idle cycles ahead of it
   task automatic send_request(input logic [OP_W-1:0] op,
                               input logic signed [DATA_W-1:0] val,
                               input logic signed [DATA_W-1:0] pri);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_value_in <= val;
      req_priority_in <= pri;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_queue_op(op, val, pri);
   endtask

   // hold the request side until every response is back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // compare one accepted response against the oldest expectation
   task automatic check_response();
      queue_rsp_type exp_rsp;
      if (pending_rsp.size() == 0) begin
         $error("response with nothing expected: status %0d value %0d count %0d",
                rsp_status, rsp_value_out, rsp_entry_count);
         fail_count++;
      end else begin
         exp_rsp = pending_rsp.pop_front();
         if (rsp_status !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, rsp_status);
            fail_count++;
         end
         if (rsp_value_out !== exp_rsp.value) begin
            $error("value_out: expected %0d, got %0d", exp_rsp.value, rsp_value_out);
            fail_count++;
         end
         if (rsp_entry_count !== exp_rsp.count) begin
            $error("entry_count: expected %0d, got %0d", exp_rsp.count,
                   rsp_entry_count);
            fail_count++;
         end
      end
   endtask

   // response side: check, then pick the stall for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_response();
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   // ends the run when nothing moves on either side for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // empty queue, unused opcode, field extremes and priority ties
   task automatic test_empty_and_extremes();
      send_request(OP_PEEK, $urandom(), $urandom());
      send_request(OP_DELETE, $urandom(), $urandom());
      send_request(OP_UNUSED, $urandom(), $urandom());
      send_request(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_request(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
      send_request(OP_INSERT, 32'h5555_5555, 32'hFFFF_FFFF);
      send_request(OP_UNUSED, $urandom(), $urandom());
      // tie on the top priority: lower index first
      send_request(OP_PEEK, $urandom(), $urandom());
      send_request(OP_DELETE, $urandom(), $urandom());
      send_request(OP_PEEK, $urandom(), $urandom());
      repeat (5) send_request(OP_DELETE, $urandom(), $urandom());
      send_request(OP_PEEK, $urandom(), $urandom());
      wait_for_drain();
   endtask

   // long response hold-off while requests keep coming
   task automatic test_backpressure();
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      hold_left = 150;
      repeat (6) send_request(OP_INSERT, $urandom(), $urandom());
      repeat (4) send_request(OP_PEEK, $urandom(), $urandom());
      repeat (8) send_request(OP_DELETE, $urandom(), $urandom());
      wait_for_drain();
   endtask

   // random bursts that fill, drain or mix, with varied priority spreads
   task automatic test_random_traffic(input int num_items, input int snd_pct,
                                      input int rcv_pct);
      int left;
      int burst;
      int mode;
      int pri_kind;
      int r;
      logic [OP_W-1:0] op;
      logic signed [DATA_W-1:0] pri;
      snd_idle_pct = snd_pct;
      rcv_idle_pct = rcv_pct;
      left = num_items;
      while (left > 0) begin
         burst = $urandom_range(24, 8);
         mode = $urandom_range(2);
         pri_kind = $urandom_range(2);
         while (burst > 0 && left > 0) begin
            r = $urandom_range(99);
            case (mode)
               0: op = (r < 75) ? OP_INSERT : (r < 90) ? OP_DELETE :
                       (r < 98) ? OP_PEEK : OP_UNUSED;
               1: op = (r < 20) ? OP_INSERT : (r < 75) ? OP_DELETE :
                       (r < 97) ? OP_PEEK : OP_UNUSED;
               default: op = (r < 45) ? OP_INSERT : (r < 75) ? OP_DELETE :
                             (r < 97) ? OP_PEEK : OP_UNUSED;
            endcase
            case (pri_kind)
               // narrow spread around zero forces ties
               0: pri = $signed($urandom_range(3)) - 2;
               1: begin
                  case ($urandom_range(3))
                     0: pri = 32'h8000_0000;
                     1: pri = 32'h7FFF_FFFF;
                     2: pri = 32'h0000_0000;
                     default: pri = 32'hFFFF_FFFF;
                  endcase
               end
               default: pri = $urandom();
            endcase
            send_request(op, $urandom(), pri);
            burst--;
            left--;
         end
      end
      wait_for_drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_extremes();
      test_backpressure();
      test_random_traffic(380, 6, 81);
      test_random_traffic(380, 81, 6);
      test_random_traffic(380, 0, 0);
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
